/* hdl/pcs_pkg.sv */
package pcs_pkg;

    localparam int BUS_COUNT      = 256;
    localparam int SLOT_COUNT     = 32;
    localparam int FUNCTION_COUNT = 8;

    localparam int BUS_W  = 8;
    localparam int SLOT_W = 5;
    localparam int FUNC_W = 3;
    localparam int OFF_W  = 8;
    localparam int CFG_W  = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    localparam logic KIND_READ   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_CLASS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBCLASS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERFACE = 2'd2;

    localparam logic [OFF_W-1:0] OFF_ID    = 8'h00;
    localparam logic [OFF_W-1:0] OFF_CLASS = 8'h08;
    localparam logic [OFF_W-1:0] OFF_HDR   = 8'h0C;
    localparam logic [OFF_W-1:0] OFF_IRQ   = 8'h3C;

    localparam logic [15:0] VENDOR_NONE = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ID,
        PH_CLASS,
        PH_HDR,
        PH_IRQ
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic [BUS_W-1:0]    bus;
        logic [SLOT_W-1:0]   slot;
        logic [FUNC_W-1:0]   func;
        logic [15:0]         vendor;
        logic [15:0]         device;
    } t_scan_state;

    typedef struct packed {
        logic [CFG_W-1:0] class_wanted;
        logic [CFG_W-1:0] subclass_wanted;
        logic [CFG_W-1:0] interface_wanted;
    } t_match_cfg;

    typedef struct packed {
        logic              kind;
        logic [BUS_W-1:0]  bus_number;
        logic [SLOT_W-1:0] device_slot;
        logic [FUNC_W-1:0] function_number;
        logic [OFF_W-1:0]  register_offset;
        logic              found;
        logic [15:0]       vendor_code;
        logic [15:0]       device_code;
        logic [7:0]        intr_line;
    } t_result;

endpackage

/* hdl/pcs_in_if.sv */
interface pcs_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] read_data;

    modport source (output valid, output operation, output read_data, input ready);
    modport sink   (input valid, input operation, input read_data, output ready);
endinterface

/* hdl/pcs_out_if.sv */
interface pcs_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  bus_number;
    logic [4:0]  device_slot;
    logic [2:0]  function_number;
    logic [7:0]  register_offset;
    logic        found;
    logic [15:0] vendor_code;
    logic [15:0] device_code;
    logic [7:0]  intr_line;

    modport source (output valid, output kind, output bus_number, output device_slot,
                    output function_number, output register_offset, output found,
                    output vendor_code, output device_code, output intr_line, input ready);
    modport sink   (input valid, input kind, input bus_number, input device_slot,
                    input function_number, input register_offset, input found,
                    input vendor_code, input device_code, input intr_line, output ready);
endinterface

/* hdl/pcs_step.sv */
module pcs_step (
    input  pcs_pkg::t_scan_state i_state,
    input  pcs_pkg::t_match_cfg  i_cfg,
    input  logic                 i_operation,
    input  logic [31:0]          i_read_data,
    output pcs_pkg::t_scan_state o_state,
    output logic                 o_has_result,
    output pcs_pkg::t_result     o_result
);
    import pcs_pkg::*;

    logic [FUNC_W:0] func_inc;
    logic [SLOT_W:0] slot_inc;
    logic [BUS_W:0]  bus_inc;
    logic            func_wrap;
    logic            slot_wrap;
    logic            bus_end;
    logic            class_match;

    assign func_inc  = {1'b0, i_state.func} + 1'b1;
    assign slot_inc  = {1'b0, i_state.slot} + 1'b1;
    assign bus_inc   = {1'b0, i_state.bus} + 1'b1;
    assign func_wrap = func_inc >= (FUNC_W+1)'(FUNCTION_COUNT);
    assign slot_wrap = slot_inc >= (SLOT_W+1)'(SLOT_COUNT);
    assign bus_end   = bus_inc >= (BUS_W+1)'(BUS_COUNT);

    assign class_match = (i_read_data[31:24] == i_cfg.class_wanted)
                      && (i_read_data[23:16] == i_cfg.subclass_wanted)
                      && (i_read_data[15:8]  == i_cfg.interface_wanted);

    always_comb begin
        t_scan_state      n_st;
        logic             adv_slot;
        logic             adv_func;
        logic             report;
        logic             hit;
        logic [OFF_W-1:0] offset;

        n_st         = i_state;
        adv_slot     = 1'b0;
        adv_func     = 1'b0;
        report       = 1'b0;
        hit          = 1'b0;
        offset       = OFF_ID;
        o_has_result = 1'b1;

        if (i_operation == OP_START) begin
            n_st.bus   = '0;
            n_st.slot  = '0;
            n_st.func  = '0;
            n_st.phase = PH_ID;
        end else begin
            case (i_state.phase)
                PH_ID: begin
                    if (i_read_data[15:0] == VENDOR_NONE) begin
                        if (i_state.func == '0) begin
                            adv_slot = 1'b1;
                        end else begin
                            adv_func = 1'b1;
                        end
                    end else begin
                        n_st.vendor = i_read_data[15:0];
                        n_st.device = i_read_data[31:16];
                        n_st.phase  = PH_CLASS;
                        offset      = OFF_CLASS;
                    end
                end
                PH_CLASS: begin
                    if (class_match) begin
                        n_st.phase = PH_IRQ;
                        offset     = OFF_IRQ;
                    end else if (i_state.func == '0) begin
                        n_st.phase = PH_HDR;
                        offset     = OFF_HDR;
                    end else begin
                        adv_func = 1'b1;
                    end
                end
                PH_HDR: begin
                    // Bit 7 of the header type byte marks a multi-function device.
                    if (!i_read_data[23]) begin
                        adv_slot = 1'b1;
                    end else begin
                        adv_func = 1'b1;
                    end
                end
                PH_IRQ: begin
                    n_st.phase = PH_IDLE;
                    report     = 1'b1;
                    hit        = 1'b1;
                end
                default: begin
                    o_has_result = 1'b0;
                end
            endcase
        end

        if (adv_func && !func_wrap) begin
            n_st.func  = func_inc[FUNC_W-1:0];
            n_st.phase = PH_ID;
            offset     = OFF_ID;
        end else if (adv_slot || adv_func) begin
            n_st.func  = '0;
            n_st.phase = PH_ID;
            offset     = OFF_ID;
            if (!slot_wrap) begin
                n_st.slot = slot_inc[SLOT_W-1:0];
            end else begin
                n_st.slot = '0;
                if (bus_end) begin
                    // Ran off the last bus: nothing matched.
                    n_st.bus   = '0;
                    n_st.phase = PH_IDLE;
                    report     = 1'b1;
                end else begin
                    n_st.bus = bus_inc[BUS_W-1:0];
                end
            end
        end

        o_state = n_st;

        if (hit) begin
            o_result = '{kind: KIND_REPORT, bus_number: i_state.bus,
                         device_slot: i_state.slot, function_number: i_state.func,
                         register_offset: '0, found: 1'b1,
                         vendor_code: i_state.vendor, device_code: i_state.device,
                         intr_line: i_read_data[7:0]};
        end else if (report) begin
            o_result = '{kind: KIND_REPORT, default: '0};
        end else begin
            o_result = '{kind: KIND_READ, bus_number: n_st.bus,
                         device_slot: n_st.slot, function_number: n_st.func,
                         register_offset: offset, default: '0};
        end
    end

endmodule

/* hdl/pci_config_space_device_scanner.sv */
// Brute-force configuration space scanner. A start request resets the walk to bus 0,
// slot 0, function 0 and answers with a read request for the identifier word; every
// returned data word then produces exactly one result, either the next read request
// or a finished report carrying the matching device or a not-found flag. Data that
// arrives while no scan is running is dropped without a result. Each request is held
// in the input register, and its result is loaded into the output register once that
// register is free or being read, so one request can be taken every cycle while the
// output is not stalled: the only loop is the update of the scan position and phase.
// The user must write the class, subclass and interface to match through the
// configuration port only while the block is idle; the block does not enforce this.
module pci_config_space_device_scanner (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pcs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pcs_pkg::CFG_W-1:0]        i_cfg_data,
    pcs_in_if.sink                           i_item,
    pcs_out_if.source                        o_result
);
    import pcs_pkg::*;

    logic        r_in_v;
    logic        r_in_op;
    logic [31:0] r_in_data;

    t_scan_state r_state;
    t_scan_state n_state;
    t_match_cfg  r_cfg;

    logic        r_out_v;
    t_result     r_out;
    t_result     n_out;
    logic        has_result;
    logic        advance;

    pcs_step u_step (
        .i_state      (r_state),
        .i_cfg        (r_cfg),
        .i_operation  (r_in_op),
        .i_read_data  (r_in_data),
        .o_state      (n_state),
        .o_has_result (has_result),
        .o_result     (n_out)
    );

    // The held request moves on when its result has somewhere to go, or when it yields no result.
    assign advance      = r_in_v && (!r_out_v || o_result.ready || !has_result);
    assign i_item.ready = !r_in_v || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CLASS:     r_cfg.class_wanted     <= i_cfg_data;
                CFG_SUBCLASS:  r_cfg.subclass_wanted  <= i_cfg_data;
                CFG_INTERFACE: r_cfg.interface_wanted <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (i_item.ready) begin
            r_in_v <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_op   <= i_item.operation;
            r_in_data <= i_item.read_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_IDLE, default: '0};
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (advance && has_result) begin
            r_out_v <= 1'b1;
        end else if (o_result.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && has_result) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid           = r_out_v;
    assign o_result.kind            = r_out.kind;
    assign o_result.bus_number      = r_out.bus_number;
    assign o_result.device_slot     = r_out.device_slot;
    assign o_result.function_number = r_out.function_number;
    assign o_result.register_offset = r_out.register_offset;
    assign o_result.found           = r_out.found;
    assign o_result.vendor_code     = r_out.vendor_code;
    assign o_result.device_code     = r_out.device_code;
    assign o_result.intr_line       = r_out.intr_line;

endmodule

/* dv/pcs_scan_checker.sv */
`timescale 1ns / 100ps

module pcs_scan_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pcs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pcs_pkg::CFG_W-1:0]     i_cfg_data,
    pcs_in_if                             i_item,
    pcs_out_if                            i_result,
    output int                            o_fail_count,
    output int                            o_pending
);
    import pcs_pkg::*;

    t_phase            walk_phase;
    logic [BUS_W-1:0]  walk_bus;
    logic [SLOT_W-1:0] walk_slot;
    logic [FUNC_W-1:0] walk_func;
    logic [15:0]       seen_vendor;
    logic [15:0]       seen_device;
    t_match_cfg        wanted;
    t_result           expected_q[$];
    int                fails;

    function automatic t_result read_request(logic [OFF_W-1:0] offset);
        t_result r;
        r                 = '0;
        r.kind            = KIND_READ;
        r.bus_number      = walk_bus;
        r.device_slot     = walk_slot;
        r.function_number = walk_func;
        r.register_offset = offset;
        return r;
    endfunction

    // Leaving the last slot of the last bus ends the walk with a not-found report.
    function automatic void advance_slot(output t_result r);
        walk_func = '0;
        if (int'(walk_slot) + 1 >= SLOT_COUNT) begin
            walk_slot = '0;
            if (int'(walk_bus) + 1 >= BUS_COUNT) begin
                walk_bus   = '0;
                walk_phase = PH_IDLE;
                r          = '0;
                r.kind     = KIND_REPORT;
                return;
            end
            walk_bus = walk_bus + 1'b1;
        end else begin
            walk_slot = walk_slot + 1'b1;
        end
        walk_phase = PH_ID;
        r = read_request(OFF_ID);
    endfunction

    function automatic void advance_function(output t_result r);
        if (int'(walk_func) + 1 >= FUNCTION_COUNT) begin
            advance_slot(r);
        end else begin
            walk_func  = walk_func + 1'b1;
            walk_phase = PH_ID;
            r = read_request(OFF_ID);
        end
    endfunction

    function automatic bit walk_step(input logic op, input logic [31:0] d, output t_result r);
        r = '0;
        if (op == OP_START) begin
            walk_bus   = '0;
            walk_slot  = '0;
            walk_func  = '0;
            walk_phase = PH_ID;
            r = read_request(OFF_ID);
            return 1'b1;
        end
        case (walk_phase)
            PH_ID: begin
                if (d[15:0] == VENDOR_NONE) begin
                    if (walk_func == '0) advance_slot(r);
                    else advance_function(r);
                end else begin
                    seen_vendor = d[15:0];
                    seen_device = d[31:16];
                    walk_phase  = PH_CLASS;
                    r = read_request(OFF_CLASS);
                end
            end
            PH_CLASS: begin
                if (d[31:24] == wanted.class_wanted && d[23:16] == wanted.subclass_wanted &&
                    d[15:8] == wanted.interface_wanted) begin
                    walk_phase = PH_IRQ;
                    r = read_request(OFF_IRQ);
                end else if (walk_func == '0) begin
                    walk_phase = PH_HDR;
                    r = read_request(OFF_HDR);
                end else begin
                    advance_function(r);
                end
            end
            PH_HDR: begin
                // Bit 23 of the header word marks a multi-function device.
                if (!d[23]) advance_slot(r);
                else advance_function(r);
            end
            PH_IRQ: begin
                walk_phase        = PH_IDLE;
                r.kind            = KIND_REPORT;
                r.bus_number      = walk_bus;
                r.device_slot     = walk_slot;
                r.function_number = walk_func;
                r.found           = 1'b1;
                r.vendor_code     = seen_vendor;
                r.device_code     = seen_device;
                r.intr_line       = d[7:0];
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result next_req;
        bit      produced;
        if (!i_rst_n) begin
            walk_phase  = PH_IDLE;
            walk_bus    = '0;
            walk_slot   = '0;
            walk_func   = '0;
            seen_vendor = '0;
            seen_device = '0;
            wanted      = '0;
            fails       = 0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CLASS:     wanted.class_wanted     = i_cfg_data;
                    CFG_SUBCLASS:  wanted.subclass_wanted  = i_cfg_data;
                    CFG_INTERFACE: wanted.interface_wanted = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_result.valid && i_result.ready) begin
                if (expected_q.size() == 0) begin
                    $error("result arrived with nothing expected");
                    fails++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("kind", 32'(want.kind), 32'(i_result.kind));
                    check_field("bus_number", 32'(want.bus_number),
                                32'(i_result.bus_number));
                    check_field("device_slot", 32'(want.device_slot),
                                32'(i_result.device_slot));
                    check_field("function_number", 32'(want.function_number),
                                32'(i_result.function_number));
                    check_field("register_offset", 32'(want.register_offset),
                                32'(i_result.register_offset));
                    check_field("found", 32'(want.found), 32'(i_result.found));
                    check_field("vendor_code", 32'(want.vendor_code),
                                32'(i_result.vendor_code));
                    check_field("device_code", 32'(want.device_code),
                                32'(i_result.device_code));
                    check_field("intr_line", 32'(want.intr_line),
                                32'(i_result.intr_line));
                end
            end
            if (i_item.valid && i_item.ready) begin
                produced = walk_step(i_item.operation, i_item.read_data, next_req);
                if (produced) expected_q.push_back(next_req);
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_q.size();
    end

endmodule

/* dv/pci_config_space_device_scanner_test.sv */
`timescale 1ns / 100ps

module pci_config_space_device_scanner_test;
    import pcs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   fail_count;
    int                   pending;
    bit                   calm;
    bit                   hold_off;
    bit                   scan_done;
    t_match_cfg           now_wanted;

    pcs_in_if  item_if ();
    pcs_out_if result_if ();

    pci_config_space_device_scanner u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_item      (item_if),
        .o_result    (result_if)
    );

    pcs_scan_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_item       (item_if),
        .i_result     (result_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial begin
        #5_000_000;
        $display("pci_config_space_device_scanner_test: errors");
        $finish;
    end

    // A finished report means the walk is idle, so the next request should mostly be a start.
    always @(posedge clk) begin
        if (result_if.valid && result_if.ready && result_if.kind == KIND_REPORT) scan_done = 1'b1;
    end

    initial begin : result_sink
        result_if.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (hold_off) begin
                result_if.ready <= 1'b0;
                repeat (80) @(posedge clk);
                hold_off = 1'b0;
            end else begin
                result_if.ready <= calm || ($urandom_range(99) >= 35);
                @(posedge clk);
            end
        end
    end

    task automatic offer(input logic op, input logic [31:0] data);
        while (!calm && $urandom_range(99) < 35) begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        item_if.valid     <= 1'b1;
        item_if.operation <= op;
        item_if.read_data <= data;
        do @(posedge clk); while (!item_if.ready);
    endtask

    task automatic settle();
        item_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic set_match(logic [CFG_W-1:0] cls, logic [CFG_W-1:0] sub,
                             logic [CFG_W-1:0] intf);
        settle();
        write_reg(CFG_CLASS, cls);
        write_reg(CFG_SUBCLASS, sub);
        write_reg(CFG_INTERFACE, intf);
        cfg_we <= 1'b0;
        now_wanted = '{cls, sub, intf};
    endtask

    // The same word means different things in each phase, so the mix is biased toward
    // absent vendors, matching class words and multi-function headers.
    function automatic logic [31:0] make_word();
        logic [31:0] w;
        int          pick;
        w    = $urandom;
        pick = $urandom_range(99);
        if (pick < 25) w[15:0] = VENDOR_NONE;
        else if (pick < 50) w[31:8] = {now_wanted.class_wanted, now_wanted.subclass_wanted,
                                       now_wanted.interface_wanted};
        else if (pick < 65) w[23] = 1'b1;
        else if (pick < 75) w = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
        return w;
    endfunction

    task automatic random_phase(int count, bit with_calm);
        logic        op;
        logic [31:0] w;
        scan_done = 1'b1;
        for (int k = 0; k < count; k++) begin
            if (k == 60) hold_off = 1'b1;
            if (k == 150) settle();
            calm = with_calm && k >= 100 && k < 250;
            w = make_word();
            if (scan_done && $urandom_range(9) != 0) begin
                op        = OP_START;
                scan_done = 1'b0;
            end else begin
                op = ($urandom_range(99) < 3) ? OP_START : OP_DATA;
            end
            offer(op, w);
        end
        calm = 1'b0;
    endtask

    initial begin : stimulus
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= '0;
        cfg_data          <= '0;
        item_if.valid     <= 1'b0;
        item_if.operation <= OP_DATA;
        item_if.read_data <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // An index past the last register must leave the match settings alone.
        write_reg(CFG_UNUSED, 8'hA5);
        set_match(8'h0C, 8'h03, 8'h30);

        offer(OP_DATA, 32'h0000_0000);
        offer(OP_START, 32'hFFFF_FFFF);
        offer(OP_DATA, 32'hFFFF_FFFF);
        offer(OP_DATA, 32'h1234_8086);
        offer(OP_DATA, 32'h0200_0000);
        offer(OP_DATA, 32'h0080_0000);
        offer(OP_DATA, 32'hFFFF_FFFF);
        offer(OP_DATA, 32'hABCD_10EC);
        offer(OP_DATA, 32'h0C03_3100);
        repeat (5) offer(OP_DATA, 32'h0000_FFFF);
        offer(OP_DATA, 32'h0000_0000);
        offer(OP_DATA, 32'h0C03_0000);
        offer(OP_DATA, 32'hFF7F_FFFF);
        offer(OP_DATA, 32'h5678_1AF4);
        offer(OP_DATA, 32'h0C03_30FF);
        offer(OP_DATA, 32'hFFFF_FF0B);
        offer(OP_DATA, 32'hFFFF_FFFF);
        offer(OP_START, 32'h0000_0000);
        offer(OP_DATA, 32'h0001_0001);
        offer(OP_START, 32'h1234_5678);
        offer(OP_DATA, 32'hFFFF_FFFF);

        set_match(8'hFF, 8'hFF, 8'hFF);
        random_phase(325, 1'b0);
        set_match(8'h00, 8'h00, 8'h00);
        random_phase(325, 1'b1);
        set_match(8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
        random_phase(325, 1'b0);
        set_match(8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
        random_phase(325, 1'b0);

        settle();
        if (fail_count == 0) begin
            $display("pci_config_space_device_scanner_test: clean");
        end else begin
            $display("pci_config_space_device_scanner_test: errors");
        end
        $finish;
    end

endmodule

/* pci_config_space_device_scanner.f */
hdl/pcs_pkg.sv
hdl/pcs_in_if.sv
hdl/pcs_out_if.sv
hdl/pcs_step.sv
hdl/pci_config_space_device_scanner.sv
dv/pcs_scan_checker.sv
dv/pci_config_space_device_scanner_test.sv
